FILE: rtl/gregorian_date_add_days_macros.svh
// assertion macros shared by the date adder modules
`ifndef GREGORIAN_DATE_ADD_DAYS_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_MACROS_SVH

// condition holds in the same cycle as the trigger
`define GDAD_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("date adder check failed");

// condition holds in the cycle after the trigger
`define GDAD_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("date adder check failed");

`endif

FILE: rtl/gdad_pkg.sv
// types, constants and the month length table for the date adder
package gdad_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mod_step;
        logic check;
        logic walk_step;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mod_last;
        logic bad_date;
        logic left_zero;
    } t_status;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] MOD_BASE  = 5'd25;

    // days in a month, zero for a month code that means nothing
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/gdad_ctrl.sv
// controller state machine for the date adder
`include "gregorian_date_add_days_macros.svh"

module gdad_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  gdad_pkg::t_status i_status,
    output gdad_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_done
);

    gdad_pkg::t_state r_state;
    gdad_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdad_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gdad_pkg::S_IDLE: begin
                if (start) n_state = gdad_pkg::S_MOD;
            end
            gdad_pkg::S_MOD: begin
                if (i_status.mod_last) n_state = gdad_pkg::S_CHECK;
            end
            gdad_pkg::S_CHECK: begin
                n_state = i_status.bad_date ? gdad_pkg::S_DONE : gdad_pkg::S_WALK;
            end
            gdad_pkg::S_WALK: begin
                if (i_status.left_zero) n_state = gdad_pkg::S_DONE;
            end
            gdad_pkg::S_DONE: begin
                n_state = gdad_pkg::S_IDLE;
            end
            default: begin
                n_state = gdad_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            gdad_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            gdad_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            gdad_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            gdad_pkg::S_WALK: begin
                o_cmd.walk_step = !i_status.left_zero;
            end
            gdad_pkg::S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // a done strobe is a single cycle, followed by idle
    `GDAD_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, o_done, (!o_done && !busy))
    // an accepted request starts the year reduction
    `GDAD_ASSERT_NEXT(a_accept_mod, i_clk, i_rst_n, (start && !busy), (r_state == gdad_pkg::S_MOD))
    // an exhausted count in the walk ends the request next cycle
    `GDAD_ASSERT_NEXT(a_walk_end, i_clk, i_rst_n,
        ((r_state == gdad_pkg::S_WALK) && i_status.left_zero), o_done)

endmodule

FILE: rtl/gdad_datapath.sv
// datapath for the date adder: year reduction, date check and month walk
`include "gregorian_date_add_days_macros.svh"

module gdad_datapath #(
    parameter int DAY_COUNT_BITS = 16,
    parameter int YEAR_BITS      = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gdad_pkg::t_cmd            i_cmd,
    input  logic [4:0]                i_start_day,
    input  logic [3:0]                i_start_month,
    input  logic [YEAR_BITS-1:0]      i_start_year,
    input  logic [DAY_COUNT_BITS-1:0] i_days_to_add,
    output gdad_pkg::t_status         o_status,
    output logic [4:0]                o_end_day,
    output logic [3:0]                o_end_month,
    output logic [YEAR_BITS-1:0]      o_end_year,
    output logic                      o_date_invalid,
    output logic                      o_year_overflow
);

    localparam int LW = (DAY_COUNT_BITS > 6) ? DAY_COUNT_BITS : 6;
    // reciprocal of 25 scaled by 2^RS, exact quotient for every year value
    localparam int RS = YEAR_BITS + 5;
    localparam int RW = YEAR_BITS + 1;
    localparam int PW = RS + YEAR_BITS;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RS) + 64'd24) / 64'd25);

    logic [4:0]                r_day;
    logic [3:0]                r_month;
    logic [YEAR_BITS-1:0]      r_year;
    logic [DAY_COUNT_BITS-1:0] r_left;
    logic [4:0]                r_mod25;
    logic [YEAR_BITS-1:0]      r_quot;
    logic                      r_mod_phase;
    logic                      r_invalid;
    logic                      r_wrap;

    logic       leap;
    logic [4:0] mlen;
    logic [4:0] rest;
    logic [LW-1:0] left_ext;
    logic [LW-1:0] rest_ext;
    logic [PW-1:0] year_prod;
    logic [4:0] mod_low;
    logic       year_top;

    // leap rule: divisible by 4, centuries only when divisible by 400
    assign leap = (r_year[1:0] == 2'b00)
               && !((r_mod25 == 5'd0) && (r_year[3:2] != 2'b00));
    assign mlen = gdad_pkg::month_len(r_month, leap);
    assign rest = mlen - r_day;
    assign left_ext = LW'(r_left);
    assign rest_ext = LW'(rest);
    assign year_top = (r_year == {YEAR_BITS{1'b1}});

    // year modulo 25: quotient by reciprocal multiply, then the low bits of year - 25q
    assign year_prod = PW'(r_year) * PW'(RECIP);
    assign mod_low   = r_year[4:0] - 5'(r_quot[4:0] * gdad_pkg::MOD_BASE);

    // status to the controller
    always_comb begin
        o_status.mod_last  = !r_mod_phase;
        o_status.bad_date  = (r_month == 4'd0) || (r_month > gdad_pkg::MONTH_DEC)
                          || (r_day == 5'd0) || (r_day > mlen);
        o_status.left_zero = (r_left == '0);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load) begin
            r_day       <= i_start_day;
            r_month     <= i_start_month;
            r_year      <= i_start_year;
            r_left      <= i_days_to_add;
            r_mod_phase <= 1'b1;
            r_invalid   <= 1'b0;
            r_wrap      <= 1'b0;
        end else if (i_cmd.mod_step) begin
            if (r_mod_phase) begin
                r_quot      <= year_prod[RS +: YEAR_BITS];
                r_mod_phase <= 1'b0;
            end else begin
                r_mod25 <= mod_low;
            end
        end else if (i_cmd.check) begin
            r_invalid <= o_status.bad_date;
        end else if (i_cmd.walk_step) begin
            if (left_ext > rest_ext) begin
                // leave this month for the first of the next
                r_left <= DAY_COUNT_BITS'(left_ext - rest_ext - LW'(1));
                r_day  <= gdad_pkg::DAY_FIRST;
                if (r_month == gdad_pkg::MONTH_DEC) begin
                    r_month <= gdad_pkg::MONTH_JAN;
                    if (year_top) begin
                        r_year  <= '0;
                        r_mod25 <= 5'd0;
                        r_wrap  <= 1'b1;
                    end else begin
                        r_year  <= r_year + YEAR_BITS'(1);
                        r_mod25 <= (r_mod25 == gdad_pkg::MOD_BASE - 5'd1) ? 5'd0
                                                                          : r_mod25 + 5'd1;
                    end
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else begin
                // the rest of the count fits in this month
                r_day  <= r_day + 5'(left_ext);
                r_left <= '0;
            end
        end
    end

    assign o_end_day       = r_day;
    assign o_end_month     = r_month;
    assign o_end_year      = r_year;
    assign o_date_invalid  = r_invalid;
    assign o_year_overflow = r_wrap;

    // the walk only ever sees a real month
    `GDAD_ASSERT_SAME(a_walk_month, i_clk, i_rst_n, i_cmd.walk_step,
        ((r_month >= gdad_pkg::MONTH_JAN) && (r_month <= gdad_pkg::MONTH_DEC)))
    // the walk never holds day zero
    `GDAD_ASSERT_SAME(a_walk_day, i_clk, i_rst_n, i_cmd.walk_step, (r_day != 5'd0))
    // a flagged date is never walked
    `GDAD_ASSERT_SAME(a_walk_valid, i_clk, i_rst_n, i_cmd.walk_step, !r_invalid)

endmodule

FILE: rtl/gregorian_date_add_days.sv
// top level of the gregorian date adder
//
// Adds a count of days to a Gregorian date (day, month, year).
// Request: drive i_start_day, i_start_month, i_start_year, i_days_to_add
// and raise start; the request is taken at a clock edge where start is
// high and busy is low. Inputs are sampled at that edge only.
// Result: o_done is high for exactly one cycle, and o_end_day,
// o_end_month, o_end_year, o_date_invalid, o_year_overflow are valid in
// that cycle. The receiver cannot stall; the result must be taken then.
// From accept to the o_done cycle the controller runs the year reduction,
// the date check and the month walk. The walk crosses the month boundaries
// (up to about 2150 for a 16-bit count), then adds any days left after the
// last boundary in a final step; an invalid date skips the walk.
// The year is first reduced modulo 25 by a reciprocal multiply, quotient
// then remainder, for the leap rule; then the walk crosses one month per
// cycle through the month length table. One request at a time; busy drops
// in the cycle after o_done, so a new request may follow.
// Reset (i_rst_n low, synchronous) returns the controller to idle and
// drops any request in flight; no result is given for it.
module gregorian_date_add_days #(
    parameter int DAY_COUNT_BITS = 16,
    parameter int YEAR_BITS      = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [4:0]                i_start_day,
    input  logic [3:0]                i_start_month,
    input  logic [YEAR_BITS-1:0]      i_start_year,
    input  logic [DAY_COUNT_BITS-1:0] i_days_to_add,
    output logic                      o_done,
    output logic [4:0]                o_end_day,
    output logic [3:0]                o_end_month,
    output logic [YEAR_BITS-1:0]      o_end_year,
    output logic                      o_date_invalid,
    output logic                      o_year_overflow
);

    gdad_pkg::t_cmd    cmd;
    gdad_pkg::t_status status;

    // sequencing
    gdad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    // arithmetic and date registers
    gdad_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS),
        .YEAR_BITS      (YEAR_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_start_day     (i_start_day),
        .i_start_month   (i_start_month),
        .i_start_year    (i_start_year),
        .i_days_to_add   (i_days_to_add),
        .o_status        (status),
        .o_end_day       (o_end_day),
        .o_end_month     (o_end_month),
        .o_end_year      (o_end_year),
        .o_date_invalid  (o_date_invalid),
        .o_year_overflow (o_year_overflow)
    );

endmodule
